FILE: hdl/oscillating_surface_rotation_delta_assert.svh
// Assertion macros for the rotation delta block
`ifndef OSCILLATING_SURFACE_ROTATION_DELTA_ASSERT_SVH
`define OSCILLATING_SURFACE_ROTATION_DELTA_ASSERT_SVH
`define OSRD_ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define OSRD_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

FILE: hdl/osrd_pkg.sv
// ----------------------------------------------------------------------------
// osrd_pkg
// Shared types and constants for the rotation delta block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package osrd_pkg;
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ZERO = 2'd1;
  localparam logic [1:0] MODE_SIN  = 2'd2;

  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_X    = 2'd1;
  localparam logic [1:0] AXIS_Y    = 2'd2;
  localparam logic [1:0] AXIS_Z    = 2'd3;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_RATE_X = 3'd1;
  localparam logic [2:0] REG_RATE_Y = 3'd2;
  localparam logic [2:0] REG_RATE_Z = 3'd3;
  localparam logic [2:0] REG_ORG_X  = 3'd4;
  localparam logic [2:0] REG_ORG_Y  = 3'd5;
  localparam logic [2:0] REG_ORG_Z  = 3'd6;
  localparam logic [2:0] REG_FREQ   = 3'd7;

  localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
  localparam logic signed [63:0] TWO_PI_Q24  = 64'sd105414357;
  localparam logic signed [63:0] PI_Q24      = 64'sd52707179;
  localparam logic signed [63:0] HALF_PI_Q24 = 64'sd26353589;
  localparam logic signed [63:0] GAIN_Q30    = 64'sd652032874;
  // floor(2^56 / TWO_PI_Q24), about 2^32 / 2pi, for the quotient estimate of the angle reduction
  localparam logic signed [63:0] RECIP_2PI_Q56 = (64'sd1 <<< 56) / TWO_PI_Q24;

  typedef struct packed {
    logic               func;
    logic [31:0]        time_now;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
    logic [15:0]        weight;
    logic signed [31:0] delta_a;
    logic signed [31:0] delta_b;
    logic               warn;
  } req_t;

  typedef struct packed {
    logic signed [31:0] new_delta_a;
    logic signed [31:0] new_delta_b;
    logic [1:0]         active_axis;
    logic               no_rotation_warning;
  } res_t;

  function automatic logic signed [63:0] atan_q24(input logic [4:0] i);
    logic signed [63:0] v;
    case (i)
      5'd0: v = 64'sd13176795;
      5'd1: v = 64'sd7778716;
      5'd2: v = 64'sd4110060;
      5'd3: v = 64'sd2086331;
      5'd4: v = 64'sd1047214;
      5'd5: v = 64'sd524117;
      5'd6: v = 64'sd262123;
      5'd7: v = 64'sd131069;
      default: v = (i > 5'd24) ? 64'sd0 : (64'sd1 <<< (5'd24 - i));
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

FILE: hdl/osrd_fifo.sv
// ----------------------------------------------------------------------------
// osrd_fifo
// Small request queue between front end and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module osrd_fifo
  import osrd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  req_t wdata,
  output logic full,
  input  logic rd,
  output req_t rdata,
  output logic empty
);
  req_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full  = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp] <= wdata;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr && !full) wp <= ~wp;
      if (rd && !empty) rp <= ~rp;
      cnt <= cnt + 2'(wr && !full) - 2'(rd && !empty);
    end
  end
endmodule

FILE: hdl/osrd_front.sv
// ----------------------------------------------------------------------------
// osrd_front
// Accepts requests, tags the warning flag, pushes them to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module osrd_front
  import osrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               func,
  input  logic [31:0]        time_now,
  input  logic signed [31:0] coord_a,
  input  logic signed [31:0] coord_b,
  input  logic [15:0]        weight,
  input  logic signed [31:0] delta_a,
  input  logic signed [31:0] delta_b,
  input  logic [1:0]         motion_mode,
  input  logic               rates_zero,
  input  logic               q_rd,
  output req_t               q_data,
  output logic               q_empty
);
  req_t r;
  always_comb begin
    r.func     = func;
    r.time_now = time_now;
    r.coord_a  = coord_a;
    r.coord_b  = coord_b;
    r.weight   = weight;
    r.delta_a  = delta_a;
    r.delta_b  = delta_b;
    r.warn     = (motion_mode == MODE_ZERO || motion_mode == MODE_SIN) && rates_zero;
  end

  osrd_fifo u_fifo (
    .clk(clk), .rst(rst), .wr(push), .wdata(r), .full(full),
    .rd(q_rd), .rdata(q_data), .empty(q_empty)
  );
endmodule

FILE: hdl/osrd_back.sv
// ----------------------------------------------------------------------------
// osrd_back
// Executes begin requests (CORDIC) and point requests (shared multiplier).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module osrd_back
  import osrd_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  req_t               q_data,
  output logic               q_rd,
  input  logic [1:0]         motion_mode,
  input  logic signed [31:0] rate_x,
  input  logic signed [31:0] rate_y,
  input  logic signed [31:0] rate_z,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] reduced_freq,
  output logic               o_valid,
  output res_t               o_res,
  input  logic               o_take
);
  typedef enum logic [3:0] {
    S_IDLE, S_PH, S_RED0, S_RED1, S_RED, S_CRD, S_FIN1, S_TH, S_FIN2,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_OUT
  } state_t;

  localparam int SW = $clog2(CORDIC_STEPS + 1);

  state_t state;
  req_t   req;
  logic [1:0] cur_axis, axis;
  logic signed [31:0] step_cos, step_sin, ang_x, ang_y, ang_z, theta, rate;
  logic signed [63:0] ang, cx, cy, cr, acc, f, rq;
  logic neg, second;
  logic [SW-1:0] it;
  logic signed [63:0] da, db, ra, rb;
  logic [15:0] w;

  // shared multiplier operands
  logic signed [35:0] ma;
  logic signed [32:0] mb;
  logic signed [63:0] mp;
  assign mp = 64'(ma * mb);

  // ang holds the remainder estimate, within one turn of [0, 2pi)
  logic signed [63:0] rm, r1, r2;
  always_comb begin
    rm = ang;
    if (rm < 0) rm = rm + TWO_PI_Q24;
    else if (rm >= TWO_PI_Q24) rm = rm - TWO_PI_Q24;
    r1 = (rm > PI_Q24) ? rm - TWO_PI_Q24 : rm;
  end
  assign r2 = 64'sd0;

  logic signed [63:0] xs, ys;
  assign xs = cx >>> it;
  assign ys = cy >>> it;

  logic signed [63:0] cxc, cyc;
  always_comb begin
    cxc = (cx > ONE_Q30) ? ONE_Q30 : (cx < -ONE_Q30) ? -ONE_Q30 : cx;
    cyc = (cy > ONE_Q30) ? ONE_Q30 : (cy < -ONE_Q30) ? -ONE_Q30 : cy;
    if (neg) begin
      cxc = -cxc;
      cyc = -cyc;
    end
  end

  logic signed [31:0] old_ang;
  always_comb begin
    case (axis)
      AXIS_X:  old_ang = ang_x;
      AXIS_Y:  old_ang = ang_y;
      default: old_ang = ang_z;
    endcase
  end

  logic signed [31:0] oa, ob;
  always_comb begin
    oa = (cur_axis == AXIS_X) ? origin_y : origin_x;
    ob = (cur_axis == AXIS_Z) ? origin_y : origin_z;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_PH: begin
        ma = 36'(reduced_freq);
        mb = {1'b0, req.time_now};
      end
      S_RED0: begin
        ma = ang[59:24];
        mb = RECIP_2PI_Q56[32:0];
      end
      S_RED1: begin
        ma = rq[35:0];
        mb = TWO_PI_Q24[32:0];
      end
      S_TH: begin
        ma = 36'(rate);
        mb = f[32:0];
      end
      S_P0: begin ma = da[35:0]; mb = 33'(step_cos); end
      S_P1: begin ma = db[35:0]; mb = 33'(step_sin); end
      S_P2: begin ma = db[35:0]; mb = 33'(step_cos); end
      S_P3: begin ma = da[35:0]; mb = 33'(step_sin); end
      S_P4: begin ma = 36'(ra - da); mb = {17'd0, w}; end
      S_P5: begin ma = 36'(rb - db); mb = {17'd0, w}; end
      default: ;
    endcase
  end

  logic signed [63:0] rs;
  assign rs = (acc + (64'sd1 <<< 29)) >>> 30;

  assign q_rd = (state == S_IDLE) && !q_empty;
  assign o_valid = state == S_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur_axis <= AXIS_NONE;
      step_cos <= ONE_Q30[31:0];
      step_sin <= '0;
      ang_x <= '0;
      ang_y <= '0;
      ang_z <= '0;
    end else begin
      case (state)
        S_IDLE: if (!q_empty) begin
          req <= q_data;
          w <= (q_data.weight > 16'd32768) ? 16'd32768 : q_data.weight;
          o_res.no_rotation_warning <= q_data.warn;
          if (!q_data.func) begin
            axis <= AXIS_NONE;
            f <= '0;
            if (motion_mode == MODE_ZERO || motion_mode == MODE_SIN) begin
              if (rate_x != 0) begin axis <= AXIS_X; rate <= rate_x; end
              else if (rate_y != 0) begin axis <= AXIS_Y; rate <= rate_y; end
              else if (rate_z != 0) begin axis <= AXIS_Z; rate <= rate_z; end
            end
            state <= S_PH;
          end else begin
            da <= 64'(q_data.coord_a) - 64'(oa);
            db <= 64'(q_data.coord_b) - 64'(ob);
            state <= (cur_axis == AXIS_NONE) ? S_OUT : S_P0;
            o_res.new_delta_a <= q_data.delta_a;
            o_res.new_delta_b <= q_data.delta_b;
            o_res.active_axis <= cur_axis;
          end
        end
        S_PH: begin
          cur_axis <= axis;
          o_res.active_axis <= axis;
          o_res.new_delta_a <= '0;
          o_res.new_delta_b <= '0;
          second <= 1'b0;
          ang <= mp >>> 16;
          if (axis == AXIS_NONE) state <= S_OUT;
          else if (motion_mode == MODE_SIN) state <= S_RED0;
          else state <= S_TH;
        end
        S_RED0: begin
          // quotient estimate by 2pi, low by at most one, never high
          rq <= mp >>> 32;
          state <= S_RED1;
        end
        S_RED1: begin
          ang <= ang - mp;
          state <= S_RED;
        end
        S_RED: begin
          neg <= 1'b0;
          cr <= r1;
          if (r1 > HALF_PI_Q24) begin cr <= r1 - PI_Q24; neg <= 1'b1; end
          else if (r1 < -HALF_PI_Q24) begin cr <= r1 + PI_Q24; neg <= 1'b1; end
          cx <= GAIN_Q30;
          cy <= r2;
          it <= '0;
          state <= S_CRD;
        end
        S_CRD: begin
          if (cr >= 0) begin
            cx <= cx - ys; cy <= cy + xs; cr <= cr - atan_q24(5'(it));
          end else begin
            cx <= cx + ys; cy <= cy - xs; cr <= cr + atan_q24(5'(it));
          end
          it <= it + 1'b1;
          if (it == SW'(CORDIC_STEPS - 1)) state <= second ? S_FIN2 : S_FIN1;
        end
        S_FIN1: begin
          f <= cyc;
          state <= S_TH;
        end
        S_TH: begin
          theta <= sat32((mp + (64'sd1 <<< 29)) >>> 30);
          ang <= 64'(sat32((mp + (64'sd1 <<< 29)) >>> 30))
               - ((req.time_now != 0) ? 64'(old_ang) : 64'sd0);
          second <= 1'b1;
          state <= S_RED0;
        end
        S_FIN2: begin
          step_cos <= cxc[31:0];
          step_sin <= cyc[31:0];
          case (axis)
            AXIS_X:  ang_x <= theta;
            AXIS_Y:  ang_y <= theta;
            default: ang_z <= theta;
          endcase
          state <= S_OUT;
        end
        S_P0: begin acc <= mp; state <= S_P1; end
        S_P1: begin acc <= acc + (cur_axis == AXIS_Y ? mp : -mp); state <= S_P2; end
        S_P2: begin ra <= rs; acc <= mp; state <= S_P3; end
        S_P3: begin
          acc <= acc - (cur_axis == AXIS_Y ? mp : -mp);
          state <= S_P4;
        end
        S_P4: begin
          rb <= rs;
          o_res.new_delta_a <= sat32(64'(req.delta_a) + ((mp + 64'sd16384) >>> 15));
          state <= S_P5;
        end
        S_P5: begin
          o_res.new_delta_b <= sat32(64'(req.delta_b) + ((mp + 64'sd16384) >>> 15));
          state <= S_OUT;
        end
        S_OUT: if (o_take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/oscillating_surface_rotation_delta.sv
// ----------------------------------------------------------------------------
// oscillating_surface_rotation_delta
// Rotation delta of surface points for an oscillating body.
// ----------------------------------------------------------------------------
// channel   | handshake          | payload
// request   | push / full        | func, time_now, coord_a/b, weight, delta_a/b
// result    | empty / pop        | new_delta_a/b, active_axis, no_rotation_warning
// config    | cfg_valid/cfg_ready| cfg_index, cfg_data
// Point request: states P0 to P5, then the result (P0 to P5 skipped with no axis);
// idle in the cycle after pop. Begin request: PH, then two reduction + CORDIC runs
// (sinusoidal), TH and one (zero mode), none (no axis); CORDIC_STEPS steps each.
// Reset clears the queue, axis, angles and step rotation.
// Back end stalls while a result waits; the queue keeps taking two requests.
`timescale 1ns / 1ps
module oscillating_surface_rotation_delta
  import osrd_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               func,
  input  logic [31:0]        time_now,
  input  logic signed [31:0] coord_a,
  input  logic signed [31:0] coord_b,
  input  logic [15:0]        weight,
  input  logic signed [31:0] delta_a,
  input  logic signed [31:0] delta_b,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] new_delta_a,
  output logic signed [31:0] new_delta_b,
  output logic [1:0]         active_axis,
  output logic               no_rotation_warning,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  logic [1:0] motion_mode;
  logic signed [31:0] rate_x, rate_y, rate_z, origin_x, origin_y, origin_z, reduced_freq;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_mode <= MODE_OFF;
      rate_x <= '0; rate_y <= '0; rate_z <= '0;
      origin_x <= '0; origin_y <= '0; origin_z <= '0;
      reduced_freq <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   motion_mode <= cfg_data[1:0];
        REG_RATE_X: rate_x <= cfg_data;
        REG_RATE_Y: rate_y <= cfg_data;
        REG_RATE_Z: rate_z <= cfg_data;
        REG_ORG_X:  origin_x <= cfg_data;
        REG_ORG_Y:  origin_y <= cfg_data;
        REG_ORG_Z:  origin_z <= cfg_data;
        REG_FREQ:   reduced_freq <= cfg_data;
        default: ;
      endcase
    end
  end

  req_t q_data;
  logic q_rd, q_empty, o_valid;
  res_t o_res;

  osrd_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func),
    .time_now(time_now), .coord_a(coord_a), .coord_b(coord_b), .weight(weight),
    .delta_a(delta_a), .delta_b(delta_b), .motion_mode(motion_mode),
    .rates_zero(rate_x == 0 && rate_y == 0 && rate_z == 0),
    .q_rd(q_rd), .q_data(q_data), .q_empty(q_empty)
  );

  osrd_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(q_data), .q_rd(q_rd),
    .motion_mode(motion_mode), .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .reduced_freq(reduced_freq), .o_valid(o_valid), .o_res(o_res), .o_take(pop)
  );

  assign empty = !o_valid;
  assign new_delta_a = o_res.new_delta_a;
  assign new_delta_b = o_res.new_delta_b;
  assign active_axis = o_res.active_axis;
  assign no_rotation_warning = o_res.no_rotation_warning;
endmodule

FILE: hdl/osrd_checker.sv
// ----------------------------------------------------------------------------
// osrd_checker
// Port-level checks for the rotation delta block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "oscillating_surface_rotation_delta_assert.svh"
module osrd_checker (
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input logic [31:0] new_delta_a,
  input logic [1:0] active_axis,
  input logic no_rotation_warning
);
  `OSRD_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(new_delta_a), "result changed while waiting")
  `OSRD_ASSERT_NEXT(a_drain, clk, rst, !empty && pop, empty, "result not retired")
  `OSRD_ASSERT_IMPL(a_known, clk, rst, !empty, !$isunknown({active_axis, no_rotation_warning}), "unknown result flags")
endmodule

bind oscillating_surface_rotation_delta osrd_checker u_chk (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .new_delta_a(new_delta_a),
  .active_axis(active_axis), .no_rotation_warning(no_rotation_warning)
);
